>>> sv/pidpc_pkg.sv
// pidpc_pkg: shared types, constants and the microcode ROM of the PID position
// controller. Depends on nothing; every other file of the block imports it.

package pidpc_pkg;

   // Shared multiplier and accumulator widths (fixed by the Q formats in use).
   localparam int MUL_BITS      = 33;
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int ACC_BITS      = PROD_BITS;
   localparam int STEP_BITS     = 4;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int GAIN_BITS     = 16;
   localparam int DERIV_BITS    = 16;
   localparam int ISTEP_BITS    = 32;
   localparam int LIMIT_BITS    = 15;
   localparam int DRIVE_BITS    = 16;

   // Saturation bounds of the integral term and of the inner sum.
   localparam logic signed [ACC_BITS-1:0] ITERM_SAT =
      $signed({{(ACC_BITS-49){1'b0}}, 1'b1, 48'b0});
   localparam logic signed [ACC_BITS-1:0] INNER_SAT =
      $signed({{(ACC_BITS-48){1'b0}}, 1'b1, 47'b0});

   // Register reset values.
   localparam logic signed [GAIN_BITS-1:0] GAIN_RESET  = -16'sd2400;
   localparam logic [DERIV_BITS-1:0]       DERIV_RESET = 16'd1000;
   localparam logic [ISTEP_BITS-1:0]       ISTEP_RESET = 32'd1073742;
   localparam logic [LIMIT_BITS-1:0]       LIMIT_RESET = 15'd24576;

   typedef enum logic [1:0] {
      REG_GAIN  = 2'd0,
      REG_DERIV = 2'd1,
      REG_ISTEP = 2'd2,
      REG_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_BITS-1:0] gain;
      logic [DERIV_BITS-1:0]       deriv;
      logic [ISTEP_BITS-1:0]       istep;
      logic [LIMIT_BITS-1:0]       limit;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SLO,    // low word of the error sum times integral_step
      MUL_SHI,    // high word of the error sum times integral_step
      MUL_DIFF,   // error difference times derivative_ratio
      MUL_ILO,    // low 24 bits of inner times gain
      MUL_IHI     // upper bits of inner times gain
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_PHI,
      ACC_ADD_P,
      ACC_CLAMP_I,
      ACC_ADD_PE,
      ACC_CLAMP_N,
      ACC_LOAD_P,
      ACC_ADD_P24
   } acc_op_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_NEXT,
      SEQ_EMIT    // write result when the output slot is free, else hold
   } seq_op_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        sum_update;
      seq_op_type  seq_op;
   } ctrl_word_type;

   localparam ctrl_word_type CTRL_IDLE = '{
      mul_sel: MUL_NONE, acc_op: ACC_HOLD, sum_update: 1'b0, seq_op: SEQ_IDLE};

   function automatic ctrl_word_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ctrl_word_type w;
      w = CTRL_IDLE;
      case (step)
         4'd0: w = '{MUL_NONE, ACC_HOLD,     1'b1, SEQ_NEXT};
         4'd1: w = '{MUL_SLO,  ACC_HOLD,     1'b0, SEQ_NEXT};
         4'd2: w = '{MUL_SHI,  ACC_LOAD_PHI, 1'b0, SEQ_NEXT};
         4'd3: w = '{MUL_DIFF, ACC_ADD_P,    1'b0, SEQ_NEXT};
         4'd4: w = '{MUL_NONE, ACC_CLAMP_I,  1'b0, SEQ_NEXT};
         4'd5: w = '{MUL_NONE, ACC_ADD_PE,   1'b0, SEQ_NEXT};
         4'd6: w = '{MUL_NONE, ACC_CLAMP_N,  1'b0, SEQ_NEXT};
         4'd7: w = '{MUL_ILO,  ACC_HOLD,     1'b0, SEQ_NEXT};
         4'd8: w = '{MUL_IHI,  ACC_LOAD_P,   1'b0, SEQ_NEXT};
         4'd9: w = '{MUL_NONE, ACC_ADD_P24,  1'b0, SEQ_NEXT};
         4'd10: w = '{MUL_NONE, ACC_HOLD,    1'b0, SEQ_EMIT};
         default: w = CTRL_IDLE;
      endcase
      return w;
   endfunction

endpackage

>>> sv/pidpc_csr.sv
// pidpc_csr: APB-style configuration registers of the PID position controller.
// Depends on pidpc_pkg for the register layout and reset values.

module pidpc_csr
   import pidpc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index  = csr_index_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_GAIN:  cfg_in.gain  = $signed(pwdata[GAIN_BITS-1:0]);
            REG_DERIV: cfg_in.deriv = pwdata[DERIV_BITS-1:0];
            REG_ISTEP: cfg_in.istep = pwdata[ISTEP_BITS-1:0];
            REG_LIMIT: cfg_in.limit = pwdata[LIMIT_BITS-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain  <= GAIN_RESET;
         cfg_ff.deriv <= DERIV_RESET;
         cfg_ff.istep <= ISTEP_RESET;
         cfg_ff.limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_GAIN:  prdata = {{(CSR_DATA_BITS-GAIN_BITS){1'b0}}, cfg_ff.gain};
         REG_DERIV: prdata = {{(CSR_DATA_BITS-DERIV_BITS){1'b0}}, cfg_ff.deriv};
         REG_ISTEP: prdata = cfg_ff.istep;
         REG_LIMIT: prdata = {{(CSR_DATA_BITS-LIMIT_BITS){1'b0}}, cfg_ff.limit};
         default:   prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/pidpc_ucode.sv
// pidpc_ucode: step counter and microcode ROM that sequence one control tick.
// Depends on pidpc_pkg for the control word and the ROM contents.

module pidpc_ucode
   import pidpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          out_free,
   output logic          busy,
   output ctrl_word_type ctrl
);

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      ctrl    = busy_ff ? ucode_rom(step_ff) : CTRL_IDLE;
      if (!busy_ff) begin
         if (req_valid) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else begin
         case (ctrl.seq_op)
            SEQ_NEXT: step_in = step_ff + 1'b1;
            // last step holds until the output register can take the beat
            SEQ_EMIT: if (out_free) busy_in = 1'b0;
            default:  busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy = busy_ff;

endmodule

>>> sv/pidpc_datapath.sv
// pidpc_datapath: controller state, shared 33x33 multiplier, accumulator and
// the clamped output register. Depends on pidpc_pkg; driven by pidpc_ucode.

module pidpc_datapath
   import pidpc_pkg::*;
#(
   parameter int ERROR_BITS = 24,
   parameter int SUM_BITS   = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic signed [ERROR_BITS-1:0] error_now,
   input  cfg_type                      cfg,
   input  ctrl_word_type                ctrl,
   input  logic                         rsp_stall,
   output logic                         out_free,
   output logic                         rsp_valid,
   output logic signed [DRIVE_BITS-1:0] rsp_drive_value,
   output logic                         rsp_clamped
);

   logic signed [ERROR_BITS-1:0] e_ff, e_in;
   logic signed [ERROR_BITS-1:0] prev_ff, prev_in;
   logic signed [ERROR_BITS:0]   diff_ff, diff_in;
   logic signed [SUM_BITS-1:0]   sum_ff, sum_in;
   logic signed [PROD_BITS-1:0]  p_ff, p_in;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_BITS-1:0] drive_ff, drive_in;
   logic                         clamped_ff, clamped_in;

   logic signed [SUM_BITS:0]     sum_wide;
   logic signed [63:0]           sum_ext;
   logic signed [MUL_BITS-1:0]   mul_a, mul_b;
   logic signed [ACC_BITS-11:0]  v;
   logic signed [ACC_BITS-11:0]  lim_ext;
   logic [DRIVE_BITS-1:0]        lim_pos;
   logic                         emit;

   assign sum_wide = (SUM_BITS+1)'(sum_ff) + (SUM_BITS+1)'(e_ff);
   assign sum_ext  = 64'(sum_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (ctrl.seq_op == SEQ_EMIT) && out_free;

   // error, difference and saturating sum
   always_comb begin
      e_in    = load ? error_now : e_ff;
      prev_in = prev_ff;
      diff_in = diff_ff;
      sum_in  = sum_ff;
      if (ctrl.sum_update) begin
         diff_in = (ERROR_BITS+1)'(e_ff) - (ERROR_BITS+1)'(prev_ff);
         prev_in = e_ff;
         if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
            sum_in = sum_wide[SUM_BITS] ? $signed({1'b1, {(SUM_BITS-1){1'b0}}})
                                        : $signed({1'b0, {(SUM_BITS-1){1'b1}}});
         end else begin
            sum_in = sum_wide[SUM_BITS-1:0];
         end
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.mul_sel)
         MUL_SLO: begin
            mul_a = $signed({1'b0, sum_ext[31:0]});
            mul_b = $signed({1'b0, cfg.istep});
         end
         MUL_SHI: begin
            mul_a = $signed({sum_ext[63], sum_ext[63:32]});
            mul_b = $signed({1'b0, cfg.istep});
         end
         MUL_DIFF: begin
            mul_a = MUL_BITS'(diff_ff);
            mul_b = $signed({{(MUL_BITS-DERIV_BITS){1'b0}}, cfg.deriv});
         end
         MUL_ILO: begin
            mul_a = $signed({{(MUL_BITS-24){1'b0}}, acc_ff[23:0]});
            mul_b = $signed({{(MUL_BITS-GAIN_BITS){cfg.gain[GAIN_BITS-1]}}, cfg.gain});
         end
         MUL_IHI: begin
            mul_a = $signed({{(MUL_BITS-25){acc_ff[48]}}, acc_ff[48:24]});
            mul_b = $signed({{(MUL_BITS-GAIN_BITS){cfg.gain[GAIN_BITS-1]}}, cfg.gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      p_in = (ctrl.mul_sel == MUL_NONE) ? p_ff : mul_a * mul_b;
   end

   always_comb begin
      acc_in = acc_ff;
      case (ctrl.acc_op)
         ACC_HOLD:     acc_in = acc_ff;
         // low-word product is unsigned: keep its upper 32 bits (floor)
         ACC_LOAD_PHI: acc_in = $signed({{(ACC_BITS-32){1'b0}}, p_ff[63:32]});
         ACC_ADD_P:    acc_in = acc_ff + p_ff;
         ACC_CLAMP_I: begin
            if (acc_ff > ITERM_SAT)       acc_in = ITERM_SAT;
            else if (acc_ff < -ITERM_SAT) acc_in = -ITERM_SAT;
         end
         ACC_ADD_PE:   acc_in = acc_ff + p_ff + ACC_BITS'(e_ff);
         ACC_CLAMP_N: begin
            if (acc_ff > INNER_SAT)       acc_in = INNER_SAT;
            else if (acc_ff < -INNER_SAT) acc_in = -INNER_SAT;
         end
         ACC_LOAD_P:   acc_in = p_ff;
         ACC_ADD_P24:  acc_in = acc_ff + (p_ff <<< 24);
         default:      acc_in = acc_ff;
      endcase
   end

   // Q.20 product to Q5.10 by an arithmetic shift, then the output clamp
   assign v       = acc_ff[ACC_BITS-1:10];
   assign lim_ext = $signed({{(ACC_BITS-10-LIMIT_BITS){1'b0}}, cfg.limit});
   assign lim_pos = {1'b0, cfg.limit};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      drive_in     = drive_ff;
      clamped_in   = clamped_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (v > lim_ext) begin
            drive_in   = $signed(lim_pos);
            clamped_in = 1'b1;
         end else if (v < -lim_ext) begin
            drive_in   = $signed(-lim_pos);
            clamped_in = 1'b1;
         end else begin
            drive_in   = v[DRIVE_BITS-1:0];
            clamped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff       <= e_in;
      diff_ff    <= diff_in;
      p_ff       <= p_in;
      acc_ff     <= acc_in;
      drive_ff   <= drive_in;
      clamped_ff <= clamped_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = drive_ff;
   assign rsp_clamped     = clamped_ff;

endmodule

>>> sv/pid_position_controller_core.sv
// PID position controller core: one position error in, one clamped drive out.
// Request channel: req_valid / req_stall carry req_error_now (Q4.20 radians).
//   A beat is taken when req_valid is high and req_stall is low.
// Result channel: rsp_valid / rsp_stall carry rsp_drive_value (Q5.10 volts)
//   and rsp_clamped. Each request beat yields exactly one result beat.
// Configuration: APB-style port, registers at byte addresses 0 (overall_gain),
//   4 (derivative_ratio), 8 (integral_step), 12 (output_limit); write only
//   while the core is idle. pready is tied high.
// Timing: the request is latched at the accepting edge, then an eleven-step
//   microcode program runs on one shared 33x33 multiplier (five multiplies)
//   and an accumulator. A new request is taken only once the program ends;
//   req_stall is high while the program runs.
// Stall: the result sits in an output register; a new tick may run while it
//   waits. If the next result is ready and the receiver still stalls, the last
//   step holds and req_stall stays high until the waiting beat is taken.
// Reset: synchronous, active high. Clears the error history and the error
//   sum, drops any pending result and restores the register defaults.

module pid_position_controller_core
   import pidpc_pkg::*;
#(
   parameter int ERROR_BITS = 24,
   parameter int SUM_BITS   = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ERROR_BITS-1:0] req_error_now,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DRIVE_BITS-1:0] rsp_drive_value,
   output logic                         rsp_clamped,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_BITS-1:0]     paddr,
   input  logic [CSR_DATA_BITS-1:0]     pwdata,
   output logic [CSR_DATA_BITS-1:0]     prdata,
   output logic                         pready
);

   cfg_type       cfg;
   ctrl_word_type ctrl;
   logic          busy;
   logic          out_free;
   logic          load;

   assign req_stall = busy;
   assign load      = req_valid && !busy;

   pidpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pidpc_ucode u_ucode (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .busy      (busy),
      .ctrl      (ctrl)
   );

   pidpc_datapath #(
      .ERROR_BITS (ERROR_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .error_now       (req_error_now),
      .cfg             (cfg),
      .ctrl            (ctrl),
      .rsp_stall       (rsp_stall),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_drive_value (rsp_drive_value),
      .rsp_clamped     (rsp_clamped)
   );

endmodule

>>> sim/pid_position_controller_core_tb.sv
// Testbench for pid_position_controller_core: random and directed error beats with random
// idling on both channels, checked against an in-bench fixed-point PID predictor.
// Depends on pidpc_pkg and the core; stands alone otherwise.

module pid_position_controller_core_tb;
   import pidpc_pkg::*;

   localparam int ERR_W = 24;
   localparam int SUM_W = 48;
   localparam int CLK_HALF = 6;
   localparam int IDLE_PCT = 21;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BEATS = 250;
   localparam int SETTLE_CYCLES = 16;

   localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam longint INNER_LIM = longint'(1) <<< 47;
   localparam logic signed [127:0] ITERM_LIM = 128'sd1 <<< 48;

   // directed error sequences, one per directed setting
   localparam int DEFAULT_ERRS[9] = '{0, 1, -1, 8388607, -8388608, 8388607, -8388608, 3, 0};
   localparam int EDGE_ERRS[6] = '{100, -100, 101, -101, 0, 99};
   localparam int ZERO_LIM_ERRS[3] = '{0, 7, -7};
   localparam int EXTREME_ERRS[4] = '{8388607, -8388608, 1, 0};

   typedef struct {
      logic signed [DRIVE_BITS-1:0] drive;
      logic                         clamped;
   } drive_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [ERR_W-1:0] req_error_now = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DRIVE_BITS-1:0] rsp_drive_value;
   logic rsp_clamped;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   // predictor copy of the registers and the controller history
   logic signed [GAIN_BITS-1:0] cfg_gain = GAIN_RESET;
   logic [DERIV_BITS-1:0] cfg_deriv = DERIV_RESET;
   logic [ISTEP_BITS-1:0] cfg_istep = ISTEP_RESET;
   logic [LIMIT_BITS-1:0] cfg_limit = LIMIT_RESET;
   longint last_error = 0;
   longint error_total = 0;

   logic signed [ERR_W-1:0] error_queue[$];
   drive_beat_type drive_expected[$];
   drive_beat_type drive_want;
   logic req_beat_taken = 1'b0;
   logic steady = 1'b0;
   int mismatch_count = 0;

   pid_position_controller_core #(
      .ERROR_BITS(ERR_W),
      .SUM_BITS(SUM_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_error_now(req_error_now),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_drive_value(rsp_drive_value),
      .rsp_clamped(rsp_clamped),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // One control tick: update the saturating sum, then form and clamp the drive.
   function automatic drive_beat_type compute_drive(input logic signed [ERR_W-1:0] err_in);
      longint err, total, dterm, inner, volts, lim;
      logic signed [127:0] wide_sum, wide_step, iterm;
      drive_beat_type beat;
      err = err_in;
      total = error_total + err;
      if (total > SUM_MAX) total = SUM_MAX;
      else if (total < SUM_MIN) total = SUM_MIN;
      error_total = total;
      wide_sum = total;
      wide_step = {96'd0, cfg_istep};
      iterm = (wide_sum * wide_step) >>> 32;
      if (iterm > ITERM_LIM) iterm = ITERM_LIM;
      else if (iterm < -ITERM_LIM) iterm = -ITERM_LIM;
      dterm = longint'(cfg_deriv) * (err - last_error);
      inner = err + dterm + longint'(iterm);
      if (inner > INNER_LIM) inner = INNER_LIM;
      else if (inner < -INNER_LIM) inner = -INNER_LIM;
      volts = (longint'(cfg_gain) * inner) >>> 10;   // floor to Q5.10
      lim = longint'(cfg_limit);
      beat.clamped = 1'b0;
      if (volts > lim) begin
         volts = lim;
         beat.clamped = 1'b1;
      end else if (volts < -lim) begin
         volts = -lim;
         beat.clamped = 1'b1;
      end
      beat.drive = volts[DRIVE_BITS-1:0];
      last_error = err;
      return beat;
   endfunction

   function automatic logic signed [ERR_W-1:0] random_error();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return ERR_W'(int'($urandom_range(0, 32)) - 16);
      else if (pick < 7) return ERR_W'(int'($urandom_range(0, 8192)) - 4096);
      return ERR_W'($urandom);
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Writes all four registers over the APB port; only called while the core is idle.
   task automatic write_cfg(input logic [31:0] gain_word, input logic [31:0] deriv_word,
                            input logic [31:0] istep_word, input logic [31:0] limit_word);
      logic [31:0] words[4];
      csr_index_type idx;
      words = '{gain_word, deriv_word, istep_word, limit_word};
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         @(negedge clock);
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= {idx, 2'b00};
         pwdata <= words[i];
         @(negedge clock);
         penable <= 1'b1;
         @(negedge clock);
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
         case (idx)
            REG_GAIN: cfg_gain = words[i][GAIN_BITS-1:0];
            REG_DERIV: cfg_deriv = words[i][DERIV_BITS-1:0];
            REG_ISTEP: cfg_istep = words[i][ISTEP_BITS-1:0];
            REG_LIMIT: cfg_limit = words[i][LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   endtask

   // Hold off until the sender has nothing left and every result is back.
   task automatic settle();
      do @(posedge clock);
      while (error_queue.size() != 0 || req_valid || drive_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sender: a new beat only after the current one is taken; payload held while stalled
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_beat_taken)) begin
         if (error_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_valid <= 1'b1;
            req_error_now <= error_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset) begin
         req_beat_taken = req_valid && !req_stall;
         if (req_beat_taken) begin
            drive_expected.push_back(compute_drive(req_error_now));
         end
         if (rsp_valid && !rsp_stall) begin
            if (drive_expected.size() == 0) begin
               flag_mismatch("unexpected drive beat", rsp_drive_value, 0);
            end else begin
               drive_want = drive_expected.pop_front();
               if (rsp_drive_value !== drive_want.drive)
                  flag_mismatch("drive_value", rsp_drive_value, drive_want.drive);
               if (rsp_clamped !== drive_want.clamped)
                  flag_mismatch("clamped", rsp_clamped, drive_want.clamped);
            end
         end
      end
   end

   initial begin
      #(2 * CLK_HALF * 400000);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [31:0] gain_word, deriv_word, istep_word, limit_word;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults, full-scale steps for the derivative path
      foreach (DEFAULT_ERRS[i]) error_queue.push_back(ERR_W'(DEFAULT_ERRS[i]));
      settle();

      // unity path: drive equals error, probe values at and just past the limit
      write_cfg(32'd1024, 32'd0, 32'd0, 32'd100);
      foreach (EDGE_ERRS[i]) error_queue.push_back(ERR_W'(EDGE_ERRS[i]));
      settle();

      // zero limit
      write_cfg(32'd1024, 32'd0, 32'd0, 32'd0);
      foreach (ZERO_LIM_ERRS[i]) error_queue.push_back(ERR_W'(ZERO_LIM_ERRS[i]));
      settle();

      write_cfg(32'hFFFF_8000, 32'd65535, 32'hFFFF_FFFF, 32'd32767);
      foreach (EXTREME_ERRS[i]) error_queue.push_back(ERR_W'(EXTREME_ERRS[i]));
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 4))
            0: gain_word = 32'hFFFF_8000;
            1: gain_word = 32'd32767;
            2: gain_word = 32'd0;
            default: gain_word = 32'(int'($urandom_range(0, 6000)) - 3000);
         endcase
         case ($urandom_range(0, 3))
            0: deriv_word = 32'd0;
            1: deriv_word = 32'd65535;
            2: deriv_word = $urandom_range(0, 8);
            default: deriv_word = $urandom_range(0, 65535);
         endcase
         case ($urandom_range(0, 3))
            0: istep_word = 32'd0;
            1: istep_word = 32'hFFFF_FFFF;
            2: istep_word = $urandom_range(0, 1 << 20);
            default: istep_word = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0: limit_word = 32'd0;
            1: limit_word = 32'd32767;
            default: limit_word = $urandom_range(0, 32767);
         endcase
         write_cfg(gain_word, deriv_word, istep_word, limit_word);
         steady = (ph == 2);
         repeat (PHASE_BEATS) error_queue.push_back(random_error());
         settle();
      end
      steady = 1'b0;

      if (drive_expected.size() != 0)
         flag_mismatch("drive beats never returned", 0, drive_expected.size());
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> pid_position_controller_core.f
sv/pidpc_pkg.sv
sv/pidpc_csr.sv
sv/pidpc_ucode.sv
sv/pidpc_datapath.sv
sv/pid_position_controller_core.sv
sim/pid_position_controller_core_tb.sv
